@@ design/pidm_pkg.sv @@
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared types and constants for the PWM input duty meter.
// ----------------------------------------------------------------------------
package pidm_pkg;

    localparam int PERIOD_W    = 16;
    localparam int TOTAL_W     = 17;
    localparam int DUTY_W      = 7;
    localparam int SCALE_W     = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int ALU_W       = 24;  // holds high*100 and total<<6
    localparam int CNT_W       = 3;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_STARTING_EDGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_SCALE    = 2'd1;

    localparam logic               STARTING_EDGE_RST = 1'b1;
    localparam logic [SCALE_W-1:0] TICK_SCALE_RST    = 7'd4;

    // Step bounds: one scale bit per multiply step, one quotient bit per divide step
    localparam logic [CNT_W-1:0] MUL_LAST = 3'(SCALE_W - 1);
    localparam logic [CNT_W-1:0] DIV_TOP  = 3'(DUTY_W - 1);

    // x*100 = (x<<6) + (x<<5) + (x<<2)
    localparam int PCT_SH_A = 6;
    localparam int PCT_SH_B = 5;
    localparam int PCT_SH_C = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TOTAL,
        ST_PCT_A,
        ST_PCT_B,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

@@ design/pwm_input_duty_meter.sv @@
// ----------------------------------------------------------------------------
// pwm_input_duty_meter
// Input-capture PWM duty measurement with a shared add/subtract unit.
// ----------------------------------------------------------------------------
// Each capture_value transaction is a free-running counter value latched at an
// edge of the measured signal. The block alternates between expecting a rising
// and a falling edge: a rising edge updates the off period (low_time), a
// falling edge the on period (high_time). A period is the wrapped counter
// difference times tick_scale, modulo 65536. Every capture yields one result
// with both periods, their 17-bit total and floor(high*100/total), 0 when the
// total is 0. All arithmetic runs through one 24-bit adder/subtractor: the
// counter difference, seven shift-add steps for the scale multiply, one for
// the total, two for the x100, and seven restoring-divide steps, then the
// load of the result register. in_ready is low from acceptance until that
// load, which waits while the previous result has not been taken.
// The result register lets a new transaction be accepted while the last
// result still waits on out_ready. Writing starting_edge reloads the expected
// edge; configuration is to be written by the user only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pwm_input_duty_meter
    import pidm_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // capture transactions
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PERIOD_W-1:0]    capture_value,
    // result transactions
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   edge_was_rising,
    output logic [PERIOD_W-1:0]    high_time,
    output logic [PERIOD_W-1:0]    low_time,
    output logic [TOTAL_W-1:0]     total_time,
    output logic [DUTY_W-1:0]      duty_percent
);

    // Only the low 16 bits of a difference survive the modulo-65536 period,
    // so a wider counter needs no more than 16 stored bits.
    localparam int CAP_W = (COUNTER_BITS < PERIOD_W) ? COUNTER_BITS : PERIOD_W;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CAP_W-1:0]     prev_reg, prev_next;
    logic                 expect_reg, expect_next;
    logic                 start_edge_reg, start_edge_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic                 edge_reg, edge_next;
    logic [PERIOD_W-1:0]  diff_reg, diff_next;
    logic [PERIOD_W-1:0]  acc_reg, acc_next;
    logic [PERIOD_W-1:0]  high_reg, high_next;
    logic [PERIOD_W-1:0]  low_reg, low_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [ALU_W-1:0]     num_reg, num_next;
    logic [DUTY_W-1:0]    quot_reg, quot_next;

    // result register
    logic                 ovalid_reg, ovalid_next;
    logic                 oedge_reg, oedge_next;
    logic [PERIOD_W-1:0]  ohigh_reg, ohigh_next;
    logic [PERIOD_W-1:0]  olow_reg, olow_next;
    logic [TOTAL_W-1:0]   ototal_reg, ototal_next;
    logic [DUTY_W-1:0]    oduty_reg, oduty_next;

    alu_req_t             alu_req;
    logic [ALU_W:0]       alu_res;

    pidm_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = ovalid_reg;
    assign edge_was_rising = oedge_reg;
    assign high_time       = ohigh_reg;
    assign low_time        = olow_reg;
    assign total_time      = ototal_reg;
    assign duty_percent    = oduty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            prev_reg       <= '0;
            expect_reg     <= STARTING_EDGE_RST;
            start_edge_reg <= STARTING_EDGE_RST;
            scale_reg      <= TICK_SCALE_RST;
            high_reg       <= '0;
            low_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            prev_reg       <= prev_next;
            expect_reg     <= expect_next;
            start_edge_reg <= start_edge_next;
            scale_reg      <= scale_next;
            high_reg       <= high_next;
            low_reg        <= low_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // working and payload registers, no reset
    always_ff @(posedge clk)
    begin
        edge_reg   <= edge_next;
        diff_reg   <= diff_next;
        acc_reg    <= acc_next;
        total_reg  <= total_next;
        num_reg    <= num_next;
        quot_reg   <= quot_next;
        oedge_reg  <= oedge_next;
        ohigh_reg  <= ohigh_next;
        olow_reg   <= olow_next;
        ototal_reg <= ototal_next;
        oduty_reg  <= oduty_next;
    end

    always_comb
    begin
        logic [PERIOD_W-1:0] period;
        logic                load_out;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        prev_next       = prev_reg;
        expect_next     = expect_reg;
        start_edge_next = start_edge_reg;
        scale_next      = scale_reg;
        edge_next       = edge_reg;
        diff_next       = diff_reg;
        acc_next        = acc_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        total_next      = total_reg;
        num_next        = num_reg;
        quot_next       = quot_reg;
        ovalid_next     = ovalid_reg;
        oedge_next      = oedge_reg;
        ohigh_next      = ohigh_reg;
        olow_next       = olow_reg;
        ototal_next     = ototal_reg;
        oduty_next      = oduty_reg;
        alu_req         = '0;
        period          = alu_res[PERIOD_W-1:0];
        load_out        = 1'b0;

        // result taken downstream
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_STARTING_EDGE:
                begin
                    start_edge_next = cfg_data[0];
                    expect_next     = cfg_data[0];
                end
                REG_TICK_SCALE:
                begin
                    scale_next = cfg_data[SCALE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                // wrapped counter difference
                alu_req.a   = ALU_W'(capture_value[CAP_W-1:0]);
                alu_req.b   = ALU_W'(prev_reg);
                alu_req.sub = 1'b1;
                if (in_valid)
                begin
                    diff_next   = PERIOD_W'(alu_res[CAP_W-1:0]);
                    prev_next   = capture_value[CAP_W-1:0];
                    edge_next   = expect_reg;
                    expect_next = ~expect_reg;
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // shift-add, one scale bit per step, modulo 65536
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = scale_reg[cnt_reg] ?
                            ALU_W'(PERIOD_W'(diff_reg << cnt_reg)) : '0;
                acc_next  = period;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    if (edge_reg)
                    begin
                        low_next = period;
                    end
                    else
                    begin
                        high_next = period;
                    end
                    state_next = ST_TOTAL;
                end
            end

            ST_TOTAL:
            begin
                alu_req.a  = ALU_W'(high_reg);
                alu_req.b  = ALU_W'(low_reg);
                total_next = alu_res[TOTAL_W-1:0];
                state_next = ST_PCT_A;
            end

            ST_PCT_A:
            begin
                alu_req.a  = ALU_W'(high_reg) << PCT_SH_A;
                alu_req.b  = ALU_W'(high_reg) << PCT_SH_B;
                num_next   = alu_res[ALU_W-1:0];
                state_next = ST_PCT_B;
            end

            ST_PCT_B:
            begin
                alu_req.a  = num_reg;
                alu_req.b  = ALU_W'(high_reg) << PCT_SH_C;
                num_next   = alu_res[ALU_W-1:0];
                quot_next  = '0;
                cnt_next   = DIV_TOP;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // restoring divide, one quotient bit per step
                alu_req.a   = num_reg;
                alu_req.b   = ALU_W'(total_reg) << cnt_reg;
                alu_req.sub = 1'b1;
                if (alu_res[ALU_W])
                begin
                    num_next           = alu_res[ALU_W-1:0];
                    quot_next[cnt_reg] = 1'b1;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                load_out = !ovalid_reg || out_ready;
                if (load_out)
                begin
                    ovalid_next = 1'b1;
                    oedge_next  = edge_reg;
                    ohigh_next  = high_reg;
                    olow_next   = low_reg;
                    ototal_next = total_reg;
                    oduty_next  = (total_reg == '0) ? '0 : quot_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/pidm_alu.sv @@
// ----------------------------------------------------------------------------
// pidm_alu
// Shared adder/subtractor; carry out is the no-borrow flag on subtract.
// ----------------------------------------------------------------------------
module pidm_alu
    import pidm_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W:0]   result
);

    logic [ALU_W-1:0] b_eff;

    assign b_eff  = req.sub ? ~req.b : req.b;
    assign result = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};

endmodule

@@ design/pidm_checker.sv @@
// ----------------------------------------------------------------------------
// pidm_checker
// Port-level checks on the PWM input duty meter, bound to the top level.
// ----------------------------------------------------------------------------
module pidm_checker
    import pidm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                edge_was_rising,
    input logic [PERIOD_W-1:0] high_time,
    input logic [PERIOD_W-1:0] low_time,
    input logic [TOTAL_W-1:0]  total_time,
    input logic [DUTY_W-1:0]   duty_percent
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(high_time) && $stable(low_time)
            && $stable(edge_was_rising) && $stable(duty_percent))
        else $error("result payload changed while stalled");

    // total must equal the sum of the reported periods
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_time == ({1'b0, high_time} + {1'b0, low_time}))
        else $error("total_time is not high_time + low_time");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_percent <= DUTY_W'(100))
        else $error("duty_percent above 100");

    // the shared unit is busy after an accepted capture, so in_ready must drop
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("capture accepted while the unit was busy");

endmodule

bind pwm_input_duty_meter pidm_checker u_pidm_checker (.*);
